// File: rtl/core/symbol_tile_cache_lookup_top_defines.svh
// Assertion macros for the symbol tile cache lookup RTL.
`ifndef SYMBOL_TILE_CACHE_LOOKUP_TOP_DEFINES_SVH
`define SYMBOL_TILE_CACHE_LOOKUP_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset.
`define STC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked at every clock edge, reset included.
`define STC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define STC_ASSERT(label, clk, rst_n, prop, msg)
`define STC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: rtl/core/stc_pkg.sv
// Types and constants of the symbol tile cache lookup.
package stc_pkg;

  localparam int unsigned CacheEntriesDflt = 16;

  localparam int unsigned ReqDimW  = 13;
  localparam int unsigned DimW     = 12;
  localparam int unsigned SymbolW  = 16;
  localparam int unsigned StyleW   = 64;
  localparam int unsigned ColorW   = 36;
  localparam int unsigned SlotW    = 4;

  localparam logic [ReqDimW-1:0] DefaultDimCode = '1;

  typedef struct packed {
    logic [DimW-1:0]    size_w;
    logic [DimW-1:0]    size_h;
    logic [SymbolW-1:0] symbol;
    logic [StyleW-1:0]  outline_width;
    logic [StyleW-1:0]  rotation;
    logic [StyleW-1:0]  scale;
    logic [ColorW-1:0]  color_fill;
    logic [ColorW-1:0]  color_back;
    logic [ColorW-1:0]  color_outline;
  } key_t;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] slot;
    logic             evicted;
    logic [DimW-1:0]  used_width;
    logic [DimW-1:0]  used_height;
  } rsp_t;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StDone
  } ctrl_state_e;

endpackage

// File: rtl/core/stc_if.sv
// Request and response channel interfaces of the symbol tile cache lookup.
interface stc_req_if;
  logic                                valid;
  logic                                ready;
  logic signed [stc_pkg::ReqDimW-1:0]  tile_width;
  logic signed [stc_pkg::ReqDimW-1:0]  tile_height;
  logic        [stc_pkg::SymbolW-1:0]  symbol_id;
  logic        [stc_pkg::DimW-1:0]     symbol_size_x;
  logic        [stc_pkg::DimW-1:0]     symbol_size_y;
  logic        [stc_pkg::StyleW-1:0]   outline_width_bits;
  logic        [stc_pkg::StyleW-1:0]   rotation_bits;
  logic        [stc_pkg::StyleW-1:0]   scale_bits;
  logic        [stc_pkg::ColorW-1:0]   fill_color;
  logic        [stc_pkg::ColorW-1:0]   background_color;
  logic        [stc_pkg::ColorW-1:0]   outline_color;

  modport source (
    output valid, tile_width, tile_height, symbol_id, symbol_size_x, symbol_size_y,
           outline_width_bits, rotation_bits, scale_bits, fill_color,
           background_color, outline_color,
    input  ready
  );
  modport sink (
    input  valid, tile_width, tile_height, symbol_id, symbol_size_x, symbol_size_y,
           outline_width_bits, rotation_bits, scale_bits, fill_color,
           background_color, outline_color,
    output ready
  );
endinterface

interface stc_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [stc_pkg::SlotW-1:0]       slot;
  logic                            evicted;
  logic [stc_pkg::DimW-1:0]        used_width;
  logic [stc_pkg::DimW-1:0]        used_height;

  modport source (
    output valid, hit, slot, evicted, used_width, used_height,
    input  ready
  );
  modport sink (
    input  valid, hit, slot, evicted, used_width, used_height,
    output ready
  );
endinterface

// File: rtl/core/symbol_tile_cache_lookup_top.sv
// Top level of the symbol tile cache lookup: key resolution, tag store and sequencer.
//
//   Channel  Dir  Handshake      Beat contents
//   req_i    in   valid / ready  tile key: size request, symbol, style and color fields
//   rsp_o    out  valid / ready  hit, slot, evicted, resolved width and height
//
// A request is accepted in the idle state, then the tag store is swept at one entry per
// cycle (the whole filled part on a miss, stopping at the match on a hit), then the result
// is loaded in the done state; the single tag memory read port sets this sweep rate.
// Reset empties the store through the fill count; no clearing pass is needed.
// A result waits in the output register while the next request is accepted and searched.
// The load cycle of that next request stalls until the waiting result is taken.
module symbol_tile_cache_lookup_top #(
  parameter int unsigned CacheEntries = stc_pkg::CacheEntriesDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stc_req_if.sink     req_i,
  stc_rsp_if.source   rsp_o
);

  localparam int unsigned IdxW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;

  stc_pkg::key_t   in_key;
  stc_pkg::key_t   rd_data;
  stc_pkg::key_t   wr_data;
  stc_pkg::rsp_t   rsp;
  logic            rd_en;
  logic            wr_en;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_addr;
  logic            in_ready;
  logic            out_valid;

  stc_key_resolve u_key_resolve (
    .tile_width_i         (req_i.tile_width),
    .tile_height_i        (req_i.tile_height),
    .symbol_id_i          (req_i.symbol_id),
    .symbol_size_x_i      (req_i.symbol_size_x),
    .symbol_size_y_i      (req_i.symbol_size_y),
    .outline_width_bits_i (req_i.outline_width_bits),
    .rotation_bits_i      (req_i.rotation_bits),
    .scale_bits_i         (req_i.scale_bits),
    .fill_color_i         (req_i.fill_color),
    .background_color_i   (req_i.background_color),
    .outline_color_i      (req_i.outline_color),
    .key_o                (in_key)
  );

  stc_tag_mem #(
    .CacheEntries (CacheEntries)
  ) u_tag_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  stc_ctrl #(
    .CacheEntries (CacheEntries)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_i.valid),
    .in_ready_o    (in_ready),
    .in_key_i      (in_key),
    .out_valid_o   (out_valid),
    .out_ready_i   (rsp_o.ready),
    .out_rsp_o     (rsp),
    .mem_rd_en_o   (rd_en),
    .mem_rd_addr_o (rd_addr),
    .mem_rd_data_i (rd_data),
    .mem_wr_en_o   (wr_en),
    .mem_wr_addr_o (wr_addr),
    .mem_wr_data_o (wr_data)
  );

  assign req_i.ready       = in_ready;
  assign rsp_o.valid       = out_valid;
  assign rsp_o.hit         = rsp.hit;
  assign rsp_o.slot        = rsp.slot;
  assign rsp_o.evicted     = rsp.evicted;
  assign rsp_o.used_width  = rsp.used_width;
  assign rsp_o.used_height = rsp.used_height;

endmodule

// File: rtl/core/stc_key_resolve.sv
// Tile size resolution and assembly of the lookup key from a request beat.
module stc_key_resolve (
  input  logic signed [stc_pkg::ReqDimW-1:0] tile_width_i,
  input  logic signed [stc_pkg::ReqDimW-1:0] tile_height_i,
  input  logic        [stc_pkg::SymbolW-1:0] symbol_id_i,
  input  logic        [stc_pkg::DimW-1:0]    symbol_size_x_i,
  input  logic        [stc_pkg::DimW-1:0]    symbol_size_y_i,
  input  logic        [stc_pkg::StyleW-1:0]  outline_width_bits_i,
  input  logic        [stc_pkg::StyleW-1:0]  rotation_bits_i,
  input  logic        [stc_pkg::StyleW-1:0]  scale_bits_i,
  input  logic        [stc_pkg::ColorW-1:0]  fill_color_i,
  input  logic        [stc_pkg::ColorW-1:0]  background_color_i,
  input  logic        [stc_pkg::ColorW-1:0]  outline_color_i,
  output stc_pkg::key_t                      key_o
);

  logic                       use_default;
  logic [stc_pkg::DimW-1:0]   natural_max;
  logic [stc_pkg::DimW-1:0]   width_clamped;
  logic [stc_pkg::DimW-1:0]   height_clamped;

  always_comb begin
    use_default = (tile_width_i == stc_pkg::DefaultDimCode) ||
                  (tile_height_i == stc_pkg::DefaultDimCode);
    natural_max = (symbol_size_x_i > symbol_size_y_i) ? symbol_size_x_i : symbol_size_y_i;
    // Negative requests other than the default code saturate to zero.
    width_clamped  = tile_width_i[stc_pkg::ReqDimW-1] ? '0
                                                      : tile_width_i[stc_pkg::DimW-1:0];
    height_clamped = tile_height_i[stc_pkg::ReqDimW-1] ? '0
                                                       : tile_height_i[stc_pkg::DimW-1:0];

    key_o.size_w        = use_default ? natural_max : width_clamped;
    key_o.size_h        = use_default ? natural_max : height_clamped;
    key_o.symbol        = symbol_id_i;
    key_o.outline_width = outline_width_bits_i;
    key_o.rotation      = rotation_bits_i;
    key_o.scale         = scale_bits_i;
    key_o.color_fill    = fill_color_i;
    key_o.color_back    = background_color_i;
    key_o.color_outline = outline_color_i;
  end

endmodule

// File: rtl/core/stc_tag_mem.sv
// Tag store: one synchronous memory of keys, one write and one registered read port.
module stc_tag_mem #(
  parameter  int unsigned CacheEntries = stc_pkg::CacheEntriesDflt,
  localparam int unsigned IdxW         = (CacheEntries > 1) ? $clog2(CacheEntries) : 1
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [IdxW-1:0]     rd_addr_i,
  output stc_pkg::key_t       rd_data_o,
  input  logic                wr_en_i,
  input  logic [IdxW-1:0]     wr_addr_i,
  input  stc_pkg::key_t       wr_data_i
);

  stc_pkg::key_t mem_q [CacheEntries];
  stc_pkg::key_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/stc_ctrl.sv
// Lookup sequencer: sweeps the tag store, allocates on a miss and holds the result beat.
`include "symbol_tile_cache_lookup_top_defines.svh"

module stc_ctrl #(
  parameter  int unsigned CacheEntries = stc_pkg::CacheEntriesDflt,
  localparam int unsigned IdxW         = (CacheEntries > 1) ? $clog2(CacheEntries) : 1,
  localparam int unsigned CntW         = $clog2(CacheEntries + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  stc_pkg::key_t    in_key_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output stc_pkg::rsp_t    out_rsp_o,
  output logic             mem_rd_en_o,
  output logic [IdxW-1:0]  mem_rd_addr_o,
  input  stc_pkg::key_t    mem_rd_data_i,
  output logic             mem_wr_en_o,
  output logic [IdxW-1:0]  mem_wr_addr_o,
  output stc_pkg::key_t    mem_wr_data_o
);

  localparam logic [CntW-1:0] FullCount = CntW'(CacheEntries);
  localparam logic [IdxW-1:0] LastIdx   = IdxW'(CacheEntries - 1);

  stc_pkg::ctrl_state_e state_q, state_d;
  stc_pkg::key_t        key_q, key_d;
  stc_pkg::rsp_t        rsp_q, rsp_d;
  logic [CntW-1:0]      rd_cnt_q, rd_cnt_d;
  logic [CntW-1:0]      fill_q, fill_d;
  logic [IdxW-1:0]      oldest_q, oldest_d;
  logic [IdxW-1:0]      cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]      slot_q, slot_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic                 hit_q, hit_d;
  logic                 evict_q, evict_d;
  logic                 out_vld_q, out_vld_d;

  logic                 issue;
  logic                 match;
  logic                 full;
  logic                 miss;
  logic                 out_free;
  logic [IdxW-1:0]      alloc_idx;

  assign issue     = (state_q == stc_pkg::StSearch) && (rd_cnt_q < fill_q);
  assign match     = (state_q == stc_pkg::StSearch) && cmp_vld_q && (mem_rd_data_i == key_q);
  assign full      = (fill_q == FullCount);
  assign miss      = (state_q == stc_pkg::StSearch) && !issue && !match;
  assign out_free  = !out_vld_q || out_ready_i;
  assign alloc_idx = full ? oldest_q : fill_q[IdxW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stc_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = stc_pkg::StSearch;
        end
      end
      stc_pkg::StSearch: begin
        if (match || !issue) begin
          state_d = stc_pkg::StDone;
        end
      end
      stc_pkg::StDone: begin
        if (out_free) begin
          state_d = stc_pkg::StIdle;
        end
      end
      default: state_d = stc_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == stc_pkg::StIdle);
    mem_rd_en_o   = issue;
    mem_rd_addr_o = rd_cnt_q[IdxW-1:0];
    mem_wr_en_o   = miss;
    mem_wr_addr_o = alloc_idx;
    mem_wr_data_o = key_q;
    out_valid_o   = out_vld_q;
    out_rsp_o     = rsp_q;
  end

  always_comb begin
    key_d     = key_q;
    rsp_d     = rsp_q;
    rd_cnt_d  = rd_cnt_q;
    fill_d    = fill_q;
    oldest_d  = oldest_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = 1'b0;
    slot_d    = slot_q;
    hit_d     = hit_q;
    evict_d   = evict_q;
    out_vld_d = out_vld_q && !out_ready_i;

    unique case (state_q)
      stc_pkg::StIdle: begin
        if (in_valid_i) begin
          key_d    = in_key_i;
          rd_cnt_d = '0;
        end
      end
      stc_pkg::StSearch: begin
        cmp_vld_d = issue;
        cmp_idx_d = rd_cnt_q[IdxW-1:0];
        if (issue) begin
          rd_cnt_d = rd_cnt_q + CntW'(1);
        end
        if (match) begin
          hit_d   = 1'b1;
          evict_d = 1'b0;
          slot_d  = cmp_idx_q;
        end else if (!issue) begin
          hit_d   = 1'b0;
          evict_d = full;
          slot_d  = alloc_idx;
          if (full) begin
            oldest_d = (oldest_q == LastIdx) ? '0 : oldest_q + IdxW'(1);
          end else begin
            fill_d = fill_q + CntW'(1);
          end
        end
      end
      stc_pkg::StDone: begin
        if (out_free) begin
          out_vld_d         = 1'b1;
          rsp_d.hit         = hit_q;
          rsp_d.slot        = stc_pkg::SlotW'(slot_q);
          rsp_d.evicted     = evict_q;
          rsp_d.used_width  = key_q.size_w;
          rsp_d.used_height = key_q.size_h;
        end
      end
      default: begin
        cmp_vld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= stc_pkg::StIdle;
      rd_cnt_q  <= '0;
      fill_q    <= '0;
      oldest_q  <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      fill_q    <= fill_d;
      oldest_q  <= oldest_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    rsp_q     <= rsp_d;
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    hit_q     <= hit_d;
    evict_q   <= evict_d;
  end

  // The fill count never passes the number of entries.
  `STC_ASSERT_ALWAYS(a_fill_bound, clk_i, !rst_ni || (fill_q <= FullCount), "fill count overflow")
  // The replacement pointer only moves once the store is full.
  `STC_ASSERT(a_oldest_full, clk_i, rst_ni, (oldest_q != $past(oldest_q)) |-> full, "oldest slot moved before full")
  // A tag write happens only at the end of a sweep that found no match.
  `STC_ASSERT(a_write_miss, clk_i, rst_ni, mem_wr_en_o |=> (state_q == stc_pkg::StDone) && !hit_q, "tag write without miss")
  // A hit always points at a slot that was filled.
  `STC_ASSERT(a_hit_valid, clk_i, rst_ni, ((state_q == stc_pkg::StDone) && hit_q) |-> (CntW'(slot_q) < fill_q), "hit on an empty slot")
  // An eviction is reported only while the store is full.
  `STC_ASSERT(a_evict_full, clk_i, rst_ni, ((state_q == stc_pkg::StDone) && evict_q) |-> full, "eviction while not full")

endmodule
